// ===== hdl/pbs_pkg.sv =====
// pbs_pkg: shared types and constants for periodic_block_statistics.
// No dependencies.
package pbs_pkg;
	localparam int SampleBits = 16;
	localparam int FracBits = 8;
	localparam int MaxPeriod = 4096;
	localparam int LenBits = 13;
	localparam int SumBits = 28;
	// a full period of -32768 gives exactly 2^42
	localparam int SqBits = 43;
	localparam int OutBits = 24;
	localparam int MagBits = 28;
	localparam int ProdBits = 56;
	// Scaled variance needs diff/n^2 << 16, diff < 2^56.
	localparam int VarBits = 72;
	localparam int RootBits = 36;

	// Work carried from the front part to the back part on a period close.
	typedef struct packed {
		logic [LenBits-1:0] n;
		logic sum_neg;
		logic [MagBits-1:0] mag;
		logic [SqBits-1:0] sq;
		logic signed [SampleBits-1:0] min_v;
		logic signed [SampleBits-1:0] max_v;
	} close_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV_MEAN, ST_DIV_VAR, ST_SQRT
	} back_state_t;
endpackage

// ===== hdl/periodic_block_statistics.sv =====
// periodic_block_statistics: top level, handshakes, front/back split.
// Depends on pbs_pkg, pbs_front, pbs_back.
//  channel | valid      | ready      | payload
//  cfg     | cfg_valid  | cfg_ready  | cfg_data (period_length)
//  in      | in_valid   | in_ready   | sample
//  out     | out_valid  | out_ready  | period_done, mean_value, std_deviation, min, max
// An item that does not close a period is accepted, then loaded into the
// output register once that register is free. An item that closes a period
// keeps the input closed after it is accepted while the back part runs:
// multiply, mean divide, variance divide, square root, result load.
// A waiting result does not block the input; one more item can be held
// behind it. Reset: period_length 64, all statistics zero.
module periodic_block_statistics (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pbs_pkg::LenBits-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [pbs_pkg::SampleBits-1:0] sample,
	output logic out_valid,
	input  logic out_ready,
	output logic period_done,
	output logic signed [pbs_pkg::OutBits-1:0] mean_value,
	output logic [pbs_pkg::OutBits-1:0] std_deviation,
	output logic signed [pbs_pkg::SampleBits-1:0] minimum_value,
	output logic signed [pbs_pkg::SampleBits-1:0] maximum_value
);
	logic [pbs_pkg::LenBits-1:0] len_q;
	logic take, close_now, busy, pend_q, pend_done_q, load_out;
	pbs_pkg::close_t close_data;
	logic signed [pbs_pkg::OutBits-1:0] b_mean;
	logic [pbs_pkg::OutBits-1:0] b_dev;
	logic signed [pbs_pkg::SampleBits-1:0] b_min, b_max;

	assign cfg_ready = 1'b1;
	assign in_ready = !busy && !pend_q;
	assign take = in_valid && in_ready;
	assign load_out = pend_q && !busy && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_q <= pbs_pkg::LenBits'(64);
		else if (cfg_valid) len_q <= cfg_data;
	end

	pbs_front u_front (.clk, .arst_n, .len_cfg(len_q), .take, .sample,
		.close_now, .close_data);
	pbs_back u_back (.clk, .arst_n, .start(close_now), .job(close_data), .busy,
		.mean_value(b_mean), .std_deviation(b_dev),
		.minimum_value(b_min), .maximum_value(b_max));

	// result queue of one: item waits until the back part is done and the output register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0; pend_done_q <= 1'b0; out_valid <= 1'b0;
			period_done <= 1'b0; mean_value <= '0; std_deviation <= '0;
			minimum_value <= '0; maximum_value <= '0;
		end else begin
			if (take) begin
				pend_q <= 1'b1; pend_done_q <= close_now;
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid <= 1'b1;
				period_done <= pend_done_q;
				mean_value <= b_mean; std_deviation <= b_dev;
				minimum_value <= b_min; maximum_value <= b_max;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_no_take_pend: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !pend_q) else $error("pending overrun");
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("input open while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_value))
		else $error("result dropped");
endmodule

// ===== hdl/pbs_front.sv =====
// pbs_front: accumulates sum, sum of squares, min and max per period.
// Depends on pbs_pkg.
module pbs_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [pbs_pkg::LenBits-1:0] len_cfg,
	input  logic take,
	input  logic signed [pbs_pkg::SampleBits-1:0] sample,
	output logic close_now,
	output pbs_pkg::close_t close_data
);
	logic [pbs_pkg::SumBits-1:0] sum_q;
	logic [pbs_pkg::SqBits-1:0] sq_q;
	logic [pbs_pkg::LenBits-1:0] seen_q;
	logic signed [pbs_pkg::SampleBits-1:0] min_q, max_q;
	logic [pbs_pkg::LenBits-1:0] len_eff, count;
	logic signed [pbs_pkg::SampleBits-1:0] min_n, max_n;
	logic [pbs_pkg::SumBits-1:0] sum_n;
	logic [pbs_pkg::SqBits-1:0] sq_n;
	logic signed [2*pbs_pkg::SampleBits-1:0] samp_w;
	logic [2*pbs_pkg::SampleBits-1:0] prod;

	// effective length and next accumulators
	always_comb begin
		len_eff = len_cfg;
		if (len_cfg == '0) len_eff = pbs_pkg::LenBits'(1);
		if (len_cfg > pbs_pkg::LenBits'(pbs_pkg::MaxPeriod))
			len_eff = pbs_pkg::LenBits'(pbs_pkg::MaxPeriod);
		count = seen_q + 1'b1;
		min_n = (seen_q == '0 || sample < min_q) ? sample : min_q;
		max_n = (seen_q == '0 || sample > max_q) ? sample : max_q;
		samp_w = (2*pbs_pkg::SampleBits)'(sample);
		prod = samp_w * samp_w;
		sum_n = sum_q + pbs_pkg::SumBits'(sample);
		sq_n = sq_q + pbs_pkg::SqBits'(prod);
		close_now = take && (count >= len_eff);
		close_data.n = count;
		close_data.sum_neg = sum_n[pbs_pkg::SumBits-1];
		close_data.mag = sum_n[pbs_pkg::SumBits-1] ? -sum_n : sum_n;
		close_data.sq = sq_n;
		close_data.min_v = min_n;
		close_data.max_v = max_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0; sq_q <= '0; seen_q <= '0; min_q <= '0; max_q <= '0;
		end else if (take) begin
			min_q <= min_n;
			max_q <= max_n;
			if (close_now) begin
				sum_q <= '0; sq_q <= '0; seen_q <= '0;
			end else begin
				sum_q <= sum_n; sq_q <= sq_n; seen_q <= count;
			end
		end
	end

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q < pbs_pkg::LenBits'(pbs_pkg::MaxPeriod)) else $error("count overrun");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		close_now |=> seen_q == '0 && sum_q == '0) else $error("no clear");
	a_minmax: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != '0 |-> min_q <= max_q) else $error("min above max");
endmodule

// ===== hdl/pbs_back.sv =====
// pbs_back: mean, variance division and square root over many cycles.
// Depends on pbs_pkg.
module pbs_back (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  pbs_pkg::close_t job,
	output logic busy,
	output logic signed [pbs_pkg::OutBits-1:0] mean_value,
	output logic [pbs_pkg::OutBits-1:0] std_deviation,
	output logic signed [pbs_pkg::SampleBits-1:0] minimum_value,
	output logic signed [pbs_pkg::SampleBits-1:0] maximum_value
);
	localparam int NumB = 2*pbs_pkg::LenBits;
	pbs_pkg::back_state_t st_q, st_n;
	pbs_pkg::close_t job_q;
	logic [pbs_pkg::ProdBits-1:0] lhs_q, rhs_q;
	logic [NumB-1:0] nsq_q;
	logic [pbs_pkg::VarBits-1:0] num_q, quo_q;
	logic [NumB:0] rem_q;
	logic [6:0] cnt_q;
	logic [pbs_pkg::VarBits-1:0] x_q;
	logic [pbs_pkg::RootBits-1:0] root_q;
	logic [pbs_pkg::RootBits+1:0] srem_q;
	logic [NumB:0] rem_sh, rem_sub;
	logic [NumB:0] div_d;
	logic [pbs_pkg::RootBits+1:0] s_sh, s_try;

	// restoring division and bit-pair square root, one bit a cycle
	always_comb begin
		div_d = (st_q == pbs_pkg::ST_DIV_MEAN) ? (NumB+1)'(job_q.n) : {1'b0, nsq_q};
		rem_sh = {rem_q[NumB-1:0], num_q[pbs_pkg::VarBits-1]};
		rem_sub = rem_sh - div_d;
		s_sh = {srem_q[pbs_pkg::RootBits-1:0], x_q[pbs_pkg::VarBits-1 -: 2]};
		s_try = s_sh - {root_q, 2'b01};
	end

	always_comb begin
		st_n = st_q;
		case (st_q)
			pbs_pkg::ST_IDLE: if (start) st_n = pbs_pkg::ST_MUL;
			pbs_pkg::ST_MUL: st_n = pbs_pkg::ST_DIV_MEAN;
			pbs_pkg::ST_DIV_MEAN: if (cnt_q == '0) st_n = pbs_pkg::ST_DIV_VAR;
			pbs_pkg::ST_DIV_VAR: if (cnt_q == '0) st_n = pbs_pkg::ST_SQRT;
			pbs_pkg::ST_SQRT: if (cnt_q == '0) st_n = pbs_pkg::ST_IDLE;
			default: st_n = pbs_pkg::ST_IDLE;
		endcase
	end
	assign busy = (st_q != pbs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pbs_pkg::ST_IDLE;
		else st_q <= st_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_value <= '0; std_deviation <= '0;
			minimum_value <= '0; maximum_value <= '0; cnt_q <= '0;
		end else begin
			case (st_q)
				pbs_pkg::ST_IDLE: if (start) job_q <= job;
				pbs_pkg::ST_MUL: begin
					lhs_q <= pbs_pkg::ProdBits'(job_q.n) * pbs_pkg::ProdBits'(job_q.sq);
					rhs_q <= pbs_pkg::ProdBits'(job_q.mag) * pbs_pkg::ProdBits'(job_q.mag);
					nsq_q <= NumB'(job_q.n) * NumB'(job_q.n);
					// dividend {mag, 8 fraction zeros} sits in the top bits
					num_q <= pbs_pkg::VarBits'(job_q.mag) << (pbs_pkg::VarBits
						- pbs_pkg::MagBits);
					rem_q <= '0;
					cnt_q <= 7'(pbs_pkg::MagBits + pbs_pkg::FracBits - 1);
				end
				pbs_pkg::ST_DIV_MEAN, pbs_pkg::ST_DIV_VAR: begin
					if (cnt_q == '0) begin
						// last quotient bit taken straight from the subtract
						rem_q <= '0;
						if (st_q == pbs_pkg::ST_DIV_MEAN) begin
							mean_value <= job_q.sum_neg
								? -pbs_pkg::OutBits'({quo_q[pbs_pkg::VarBits-2:0], !rem_sub[NumB]})
								: pbs_pkg::OutBits'({quo_q[pbs_pkg::VarBits-2:0], !rem_sub[NumB]});
							num_q <= (lhs_q > rhs_q)
								? {lhs_q - rhs_q, {(2*pbs_pkg::FracBits){1'b0}}} : '0;
							cnt_q <= 7'(pbs_pkg::VarBits - 1);
						end else begin
							x_q <= {quo_q[pbs_pkg::VarBits-2:0], !rem_sub[NumB]};
							root_q <= '0; srem_q <= '0;
							cnt_q <= 7'(pbs_pkg::RootBits - 1);
						end
					end else begin
						if (!rem_sub[NumB]) begin
							rem_q <= rem_sub; quo_q <= {quo_q[pbs_pkg::VarBits-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh; quo_q <= {quo_q[pbs_pkg::VarBits-2:0], 1'b0};
						end
						num_q <= num_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				pbs_pkg::ST_SQRT: begin
					if (!s_try[pbs_pkg::RootBits+1]) begin
						srem_q <= s_try; root_q <= {root_q[pbs_pkg::RootBits-2:0], 1'b1};
					end else begin
						srem_q <= s_sh; root_q <= {root_q[pbs_pkg::RootBits-2:0], 1'b0};
					end
					x_q <= x_q << 2;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						std_deviation <= pbs_pkg::OutBits'({root_q[pbs_pkg::RootBits-2:0],
							!s_try[pbs_pkg::RootBits+1]});
						minimum_value <= job_q.min_v;
						maximum_value <= job_q.max_v;
					end
				end
				default: ;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy) else $error("start while busy");
	a_mul_step: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == pbs_pkg::ST_MUL |=> st_q == pbs_pkg::ST_DIV_MEAN) else $error("bad step");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == pbs_pkg::ST_SQRT && cnt_q == '0 |=> !busy) else $error("no finish");
endmodule

// ===== verif/periodic_block_statistics_test.sv =====
// periodic_block_statistics_test: self-checking testbench for the block statistics unit.
// Depends on pbs_pkg and periodic_block_statistics. Runs directed cases, then random
// periods with random handshake gaps, and checks every result against a built-in predictor.
`timescale 1ns / 100ps

module periodic_block_statistics_test;
	localparam int HoldCycles = 300;
	localparam int DrainCycles = 160;
	localparam longint CycleLimit = 1500000;
	localparam int ItemTarget = 1550;

	// Predicts the statistics and holds the expected results in order.
	class stats_scoreboard;
		logic [pbs_pkg::LenBits-1:0] period_reg;
		longint sum_acc;
		longint unsigned sq_acc;
		int unsigned seen;
		logic signed [pbs_pkg::SampleBits-1:0] run_min, run_max;
		logic signed [pbs_pkg::OutBits-1:0] hold_mean;
		logic [pbs_pkg::OutBits-1:0] hold_dev;
		logic signed [pbs_pkg::SampleBits-1:0] hold_min, hold_max;
		logic [1+2*pbs_pkg::OutBits+2*pbs_pkg::SampleBits-1:0] pending_stats[$];
		int errors;

		function void clear();
			period_reg = 13'd64;
			sum_acc = 0;
			sq_acc = 0;
			seen = 0;
			run_min = '0;
			run_max = '0;
			hold_mean = '0;
			hold_dev = '0;
			hold_min = '0;
			hold_max = '0;
			pending_stats.delete();
			errors = 0;
		endfunction

		function longint unsigned isqrt(longint unsigned x);
			longint unsigned root, bit_v;
			root = 0;
			bit_v = 64'd1 << 62;
			while (bit_v > x)
				bit_v >>= 2;
			while (bit_v != 0) begin
				if (x >= root + bit_v) begin
					x -= root + bit_v;
					root = (root >> 1) + bit_v;
				end else begin
					root >>= 1;
				end
				bit_v >>= 2;
			end
			return root;
		endfunction

		// Accepted sample: update accumulators, close the period when due.
		function void note_sample(logic signed [pbs_pkg::SampleBits-1:0] x);
			int unsigned len, count;
			longint unsigned mag, qmean, nsq, lhs, rhs, diff, q, r, scaled;
			longint xl;
			logic done;
			len = period_reg;
			if (len == 0)
				len = 1;
			if (len > pbs_pkg::MaxPeriod)
				len = pbs_pkg::MaxPeriod;
			if (seen == 0) begin
				run_min = x;
				run_max = x;
			end else begin
				if (x < run_min)
					run_min = x;
				if (x > run_max)
					run_max = x;
			end
			xl = x;
			sum_acc += xl;
			sq_acc += longint'(xl * xl);
			count = seen + 1;
			done = 1'b0;
			if (count >= len) begin
				mag = (sum_acc < 0) ? longint'(-sum_acc) : longint'(sum_acc);
				qmean = (mag << pbs_pkg::FracBits) / count;
				nsq = longint'(count) * count;
				lhs = longint'(count) * sq_acc;
				rhs = mag * mag;
				diff = (lhs > rhs) ? lhs - rhs : 0;
				q = diff / nsq;
				r = diff % nsq;
				scaled = (q << (2 * pbs_pkg::FracBits)) + ((r << (2 * pbs_pkg::FracBits)) / nsq);
				hold_mean = pbs_pkg::OutBits'((sum_acc < 0) ? -longint'(qmean) : longint'(qmean));
				hold_dev = pbs_pkg::OutBits'(isqrt(scaled));
				hold_min = run_min;
				hold_max = run_max;
				sum_acc = 0;
				sq_acc = 0;
				seen = 0;
				done = 1'b1;
			end else begin
				seen = count;
			end
			pending_stats.push_back({done, hold_mean, hold_dev, hold_min, hold_max});
		endfunction

		// Accepted result: compare with the oldest expectation.
		function void check_result(logic done, logic signed [pbs_pkg::OutBits-1:0] mean,
				logic [pbs_pkg::OutBits-1:0] dev, logic signed [pbs_pkg::SampleBits-1:0] mn,
				logic signed [pbs_pkg::SampleBits-1:0] mx);
			logic e_done;
			logic signed [pbs_pkg::OutBits-1:0] e_mean;
			logic [pbs_pkg::OutBits-1:0] e_dev;
			logic signed [pbs_pkg::SampleBits-1:0] e_min, e_max;
			if (pending_stats.size() == 0) begin
				$error("result with no expected item pending");
				errors++;
				return;
			end
			{e_done, e_mean, e_dev, e_min, e_max} = pending_stats.pop_front();
			if (done !== e_done) begin
				$error("period_done expected %0d actual %0d", e_done, done);
				errors++;
			end
			if (mean !== e_mean) begin
				$error("mean_value expected %0d actual %0d", e_mean, mean);
				errors++;
			end
			if (dev !== e_dev) begin
				$error("std_deviation expected %0d actual %0d", e_dev, dev);
				errors++;
			end
			if (mn !== e_min) begin
				$error("minimum_value expected %0d actual %0d", e_min, mn);
				errors++;
			end
			if (mx !== e_max) begin
				$error("maximum_value expected %0d actual %0d", e_max, mx);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pbs_pkg::LenBits-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [pbs_pkg::SampleBits-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic period_done;
	logic signed [pbs_pkg::OutBits-1:0] mean_value;
	logic [pbs_pkg::OutBits-1:0] std_deviation;
	logic signed [pbs_pkg::SampleBits-1:0] minimum_value, maximum_value;

	stats_scoreboard sb;
	int samples_sent = 0;
	longint cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	periodic_block_statistics dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.period_done(period_done),
		.mean_value(mean_value),
		.std_deviation(std_deviation),
		.minimum_value(minimum_value),
		.maximum_value(maximum_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Handshake monitors feed the scoreboard with values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.period_reg = cfg_data;
			if (in_valid && in_ready)
				sb.note_sample(sample);
			if (out_valid && out_ready)
				sb.check_result(period_done, mean_value, std_deviation,
					minimum_value, maximum_value);
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off, one stretch with no stalls.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && samples_sent >= 400) begin
			out_ready <= 1'b0;
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else if (samples_sent >= 700 && samples_sent < 1000) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 10);
		end
	end

	task automatic send_sample(input logic signed [pbs_pkg::SampleBits-1:0] x);
		in_valid <= 1'b1;
		sample <= x;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
		// Sender gaps, none in the quiet stretch
		if (!(samples_sent >= 700 && samples_sent < 1000) && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Period length written only with nothing in flight.
	task automatic write_period(input logic [pbs_pkg::LenBits-1:0] len);
		in_valid <= 1'b0;
		while (sb.pending_stats.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [pbs_pkg::SampleBits-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return pbs_pkg::SampleBits'(int'($urandom_range(15)) - 8);
			default: return pbs_pkg::SampleBits'($urandom);
		endcase
	endfunction

	initial begin
		int len, count;
		sb = new();
		sb.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default length partial, then one-sample periods at extremes
		send_sample(16'sh7fff);
		send_sample(-16'sd5);
		write_period(13'd1);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		// Zero length acts as one
		write_period(13'd0);
		send_sample(16'sd300);
		send_sample(-16'sd300);
		// Widest spread, negative mean
		write_period(13'd4);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		// Partial period, then length lowered below the count so far
		write_period(13'd8);
		send_sample(16'sd7);
		send_sample(-16'sd9);
		send_sample(16'sd100);
		write_period(13'd2);
		send_sample(16'sd1);
		send_sample(16'sd2);
		send_sample(16'sd3);

		// Random phases, mostly short periods, a few at and above the maximum
		while (samples_sent < ItemTarget) begin
			case ($urandom_range(19))
				0: len = pbs_pkg::MaxPeriod;
				1: len = 8191;
				2: len = $urandom_range(pbs_pkg::MaxPeriod + 1, 8190);
				3: len = 0;
				default: len = $urandom_range(1, 24);
			endcase
			write_period(pbs_pkg::LenBits'(len));
			count = (len == 0 || len > 24) ? $urandom_range(50, 300) : $urandom_range(10, 120);
			if (count > ItemTarget - samples_sent)
				count = ItemTarget - samples_sent;
			repeat (count)
				send_sample(pick_sample());
		end
		in_valid <= 1'b0;

		while (sb.pending_stats.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
